// ----- src/psc_pkg.sv -----
`default_nettype none
package psc_pkg;

  // Input request field widths and packing
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned SLOT_CODES = 256;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned IN_W       = 72;
  localparam int unsigned OUT_W      = 104;
  localparam int unsigned RES_W      = 99;

  // Header words carried from front to back
  typedef struct packed {
    logic [WORD_W-1:0] remaining_packets;
    logic [WORD_W-1:0] sequence_number;
  } hdr_t;

  // Result fields, lowest bit last
  typedef struct packed {
    logic [WORD_W-1:0] missing_count;
    logic              run_ok;
    logic [WORD_W-1:0] received_count;
    logic              progress_mark;
    logic [WORD_W-1:0] gap_size;
    logic              gap_seen;
  } result_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage
`default_nettype wire

// ----- src/psc_queue.sv -----
`default_nettype none
module psc_queue #(
  parameter int unsigned WIDTH = 72
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;

  assign full     = (fill == (PW+1)'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop)      fill <= fill + (PW+1)'(1);
      else if (pop && !push) fill <= fill - (PW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// ----- src/psc_front.sv -----
`default_nettype none
module psc_front #(
  parameter int unsigned SENDER_SLOTS = 256,
  parameter int unsigned IW           = 8
) (
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [psc_pkg::IN_W-1:0] s_tdata,
  input  wire logic                     q_full,
  input  wire logic                     clear_busy,
  output logic                          q_push,
  output logic      [IW+63:0]           q_data
);

  logic [IW-1:0]  slot_map [psc_pkg::SLOT_CODES];
  psc_pkg::hdr_t  hdr;
  logic [IW-1:0]  slot_idx;

  // Fold the sender slot onto the table depth
  for (genvar g = 0; g < psc_pkg::SLOT_CODES; g++) begin : g_map
    assign slot_map[g] = IW'(g % SENDER_SLOTS);
  end

  assign slot_idx = slot_map[s_tdata[psc_pkg::SLOT_W-1:0]];

  assign hdr.sequence_number   = s_tdata[39:8];
  assign hdr.remaining_packets = s_tdata[71:40];

  // Accept only when the queue has room and the table is initialized
  assign s_tready = !q_full && !clear_busy;
  assign q_push   = s_tvalid && s_tready;
  assign q_data   = {hdr, slot_idx};

endmodule
`default_nettype wire

// ----- src/psc_back.sv -----
`default_nettype none
module psc_back #(
  parameter int unsigned SENDER_SLOTS      = 256,
  parameter int unsigned PROGRESS_INTERVAL = 10000,
  parameter int unsigned IW                = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             report_progress,
  input  wire logic             q_empty,
  input  wire logic [IW+63:0]   q_data,
  output logic                  q_pop,
  output logic                  clear_busy,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output psc_pkg::result_t      out_result,
  output logic                  out_run_end
);

  localparam int unsigned RW = $clog2(PROGRESS_INTERVAL + 1);

  typedef struct packed {
    logic [31:0]   expected;
    logic [31:0]   count;
    logic [31:0]   total;
    logic [RW-1:0] residue;
  } slot_entry_t;

  slot_entry_t     mem [SENDER_SLOTS];
  slot_entry_t     rd_entry;
  psc_pkg::hdr_t   cur_hdr;
  logic [IW-1:0]   cur_idx;

  psc_pkg::state_t state, state_next;
  logic [IW-1:0]   clear_idx, clear_idx_next;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  slot_entry_t     mem_wdata;
  logic            load_out;

  logic [31:0]     gap;
  logic [31:0]     cnt_n;
  logic [31:0]     tot_eff;
  logic [RW-1:0]   res_n;
  logic            run_end;
  slot_entry_t     upd_entry;
  psc_pkg::result_t res;

  // Table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (q_pop) begin
      rd_entry <= mem[q_data[IW-1:0]];
      cur_idx  <= q_data[IW-1:0];
      cur_hdr  <= q_data[IW+63:IW];
    end
  end

  // Update the slot entry and form the result
  always_comb begin
    gap     = cur_hdr.sequence_number - rd_entry.expected;
    cnt_n   = rd_entry.count + 32'd1;
    tot_eff = (rd_entry.count == '0) ? cur_hdr.remaining_packets : rd_entry.total;
    if (cnt_n == '0)
      res_n = '0;
    else if (rd_entry.residue == RW'(PROGRESS_INTERVAL - 1))
      res_n = '0;
    else
      res_n = rd_entry.residue + RW'(1);
    run_end = (cur_hdr.remaining_packets == 32'd1);

    res.gap_seen       = (gap != '0) && (rd_entry.count != '0);
    res.gap_size       = gap;
    res.progress_mark  = report_progress && (res_n == '0);
    res.received_count = cnt_n;
    res.run_ok         = run_end && (cnt_n == tot_eff);
    res.missing_count  = run_end ? (tot_eff - cnt_n) : '0;

    upd_entry.expected = cur_hdr.sequence_number + 32'd1;
    upd_entry.count    = cnt_n;
    upd_entry.total    = tot_eff;
    upd_entry.residue  = res_n;
    if (run_end) upd_entry = '0;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psc_pkg::ST_CLEAR;
      clear_idx <= '0;
    end else begin
      state     <= state_next;
      clear_idx <= clear_idx_next;
    end
  end

  // Sequence clearing, reads and write-backs
  always_comb begin
    state_next     = state;
    clear_idx_next = clear_idx;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur_idx;
    mem_wdata      = upd_entry;
    load_out       = 1'b0;
    unique case (state)
      psc_pkg::ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = clear_idx;
        mem_wdata      = '0;
        clear_idx_next = clear_idx + IW'(1);
        if (clear_idx == IW'(SENDER_SLOTS - 1)) state_next = psc_pkg::ST_IDLE;
      end
      psc_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = psc_pkg::ST_EXEC;
        end
      end
      psc_pkg::ST_EXEC: begin
        if (!out_valid || out_ready) begin
          mem_we     = 1'b1;
          load_out   = 1'b1;
          state_next = psc_pkg::ST_IDLE;
        end
      end
      default: state_next = psc_pkg::ST_CLEAR;
    endcase
  end

  assign clear_busy = (state == psc_pkg::ST_CLEAR);

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_result  <= res;
      out_run_end <= run_end;
    end
  end

`ifndef ASSERT_OFF
  a_load_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == psc_pkg::ST_EXEC)
    else $error("result raised outside of update step");

  a_quiet_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == psc_pkg::ST_CLEAR |-> !out_valid && !q_pop)
    else $error("activity during table clear");

  a_mid_run_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_run_end |-> !out_result.run_ok && out_result.missing_count == '0)
    else $error("run-end fields set on mid-run result");

  a_ok_no_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.run_ok |-> out_result.missing_count == '0)
    else $error("run reported ok with missing packets");

  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.gap_seen |-> out_result.gap_size != '0)
    else $error("gap flagged with zero size");
`endif

endmodule
`default_nettype wire

// ----- src/per_sender_sequence_checker_top.sv -----
`default_nettype none
// Per-sender sequence checker.
// Slave stream s_*: one packet header per request; s_tdata holds sender_slot
// in [7:0], sequence_number in [39:8], remaining_packets in [71:40].
// Master stream m_*: one result per header, in order; m_tlast is run_end.
// Config channel cfg_*: cfg_data[0] is report_progress, always accepted;
// write it only while no header is in flight.
// Headers enter a four-entry queue; the back end reads the sender's table
// entry (registered memory read) and writes the update back from its EXEC
// state once the output register is free. It takes no new header until
// that update is written back.
// Reset: clears every table entry in turn; s_tready stays low until it
// finishes. report_progress resets to 0.
// When the receiver stalls, the result holds in the output register, the
// back end waits, and up to four headers still collect in the queue
// before s_tready drops.
module per_sender_sequence_checker_top #(
  parameter int unsigned SENDER_SLOTS      = 256,
  parameter int unsigned PROGRESS_INTERVAL = 10000
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // sender_slot, sequence_number, remaining_packets
  input  wire logic [psc_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // gap_seen, gap_size, progress_mark, received_count, run_ok,
  // missing_count, zero fill
  output logic      [psc_pkg::OUT_W-1:0] m_tdata,
  output logic                           m_tlast,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [0:0]                cfg_data
);

  localparam int unsigned IW = $clog2(SENDER_SLOTS);
  localparam int unsigned QW = IW + 64;

  logic             report_progress;
  logic             q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]    q_wdata, q_rdata;
  logic             clear_busy;
  psc_pkg::result_t out_result;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      report_progress <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      report_progress <= cfg_data[0];
    end
  end

  psc_front #(
    .SENDER_SLOTS (SENDER_SLOTS),
    .IW           (IW)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_full     (q_full),
    .clear_busy (clear_busy),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  psc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  psc_back #(
    .SENDER_SLOTS      (SENDER_SLOTS),
    .PROGRESS_INTERVAL (PROGRESS_INTERVAL),
    .IW                (IW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .report_progress (report_progress),
    .q_empty         (q_empty),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .clear_busy      (clear_busy),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_result      (out_result),
    .out_run_end     (m_tlast)
  );

  assign m_tdata = {(psc_pkg::OUT_W - psc_pkg::RES_W)'(0), out_result};

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;

  localparam int unsigned SLOTS          = psc_pkg::SLOT_CODES;
  localparam int unsigned PROGRESS_EVERY = 10000;
  localparam int unsigned QUIET_LIMIT    = 5000;

  // One checked result: run_end travels on m_tlast, the rest in m_tdata
  typedef struct packed {
    logic             run_end;
    psc_pkg::result_t res;
  } outcome_t;

  // One row of the directed table
  typedef struct packed {
    logic [psc_pkg::SLOT_W-1:0] slot;
    logic [psc_pkg::WORD_W-1:0] seq;
    logic [psc_pkg::WORD_W-1:0] rem;
    logic                       typed;
    outcome_t                   want;
  } hdr_row_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [psc_pkg::IN_W-1:0]    s_tdata;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [psc_pkg::OUT_W-1:0]   m_tdata;
  logic                        m_tlast;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [0:0]                  cfg_data;

  // Sequence tracking state per sender slot
  logic [psc_pkg::WORD_W-1:0] next_seq  [SLOTS];
  logic [psc_pkg::WORD_W-1:0] pkt_count [SLOTS];
  logic [psc_pkg::WORD_W-1:0] run_total [SLOTS];
  logic                       progress_on;

  outcome_t pending_outcomes[$];
  hdr_row_t directed_rows[$];
  int       mismatch_count;
  int       quiet_cycles;
  int       src_idle_pct;
  int       rx_stall_pct;
  logic     hold_rx;

  per_sender_sequence_checker_top #(
    .SENDER_SLOTS      (SLOTS),
    .PROGRESS_INTERVAL (PROGRESS_EVERY)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Compute the result of one header and advance the slot state
  function automatic outcome_t predict_outcome(input logic [psc_pkg::SLOT_W-1:0] slot,
                                               input logic [psc_pkg::WORD_W-1:0] seq,
                                               input logic [psc_pkg::WORD_W-1:0] rem);
    int unsigned                idx;
    logic [psc_pkg::WORD_W-1:0] prev;
    logic [psc_pkg::WORD_W-1:0] cnt;
    outcome_t                   o;
    idx  = slot % SLOTS;
    prev = pkt_count[idx];
    o = '0;
    o.res.gap_size = seq - next_seq[idx];
    o.res.gap_seen = (o.res.gap_size != 0) && (prev != 0);
    next_seq[idx] = seq + 1;
    if (prev == 0) run_total[idx] = rem;
    cnt = prev + 1;
    pkt_count[idx] = cnt;
    o.res.received_count = cnt;
    o.res.progress_mark  = progress_on && ((cnt % PROGRESS_EVERY) == 0);
    if (rem == 1) begin
      o.run_end           = 1'b1;
      o.res.run_ok        = (cnt == run_total[idx]);
      o.res.missing_count = run_total[idx] - cnt;
      next_seq[idx]  = '0;
      pkt_count[idx] = '0;
      run_total[idx] = '0;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [psc_pkg::WORD_W-1:0] got,
                             input logic [psc_pkg::WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0b want %0b", name, got, want));
  endtask

  // Offer one header, hold it until accepted, then queue its result
  task automatic send_hdr(input logic [psc_pkg::SLOT_W-1:0] slot,
                          input logic [psc_pkg::WORD_W-1:0] seq,
                          input logic [psc_pkg::WORD_W-1:0] rem, input logic typed,
                          input outcome_t want);
    logic     taken;
    outcome_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rem, seq, slot};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    pred = predict_outcome(slot, seq, rem);
    pending_outcomes.push_back(typed ? want : pred);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_progress(input logic enable);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid   <= 1'b0;
    progress_on = enable;
  endtask

  task automatic add_row(input logic [psc_pkg::SLOT_W-1:0] slot,
                         input logic [psc_pkg::WORD_W-1:0] seq,
                         input logic [psc_pkg::WORD_W-1:0] rem);
    hdr_row_t r;
    r = '0;
    r.slot = slot;
    r.seq  = seq;
    r.rem  = rem;
    directed_rows.push_back(r);
  endtask

  task automatic add_typed(input logic [psc_pkg::SLOT_W-1:0] slot,
                           input logic [psc_pkg::WORD_W-1:0] seq,
                           input logic [psc_pkg::WORD_W-1:0] rem, input logic gs,
                           input logic [psc_pkg::WORD_W-1:0] gap,
                           input logic [psc_pkg::WORD_W-1:0] cnt,
                           input logic run_end_v, input logic ok,
                           input logic [psc_pkg::WORD_W-1:0] miss);
    hdr_row_t r;
    r = '0;
    r.slot  = slot;
    r.seq   = seq;
    r.rem   = rem;
    r.typed = 1'b1;
    r.want.run_end            = run_end_v;
    r.want.res.gap_seen       = gs;
    r.want.res.gap_size       = gap;
    r.want.res.received_count = cnt;
    r.want.res.run_ok         = ok;
    r.want.res.missing_count  = miss;
    directed_rows.push_back(r);
  endtask

  // Mostly well-formed runs over a few busy slots, the rest noise
  task automatic send_random(input int count);
    logic [psc_pkg::SLOT_W-1:0] slot;
    logic [psc_pkg::WORD_W-1:0] seq;
    logic [psc_pkg::WORD_W-1:0] rem;
    int                         roll;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 70) slot = psc_pkg::SLOT_W'($urandom_range(0, 7) * 36);
      else slot = psc_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 80)      seq = next_seq[slot];
      else if (roll < 90) seq = next_seq[slot] + $urandom_range(1, 4);
      else if (roll < 95) seq = next_seq[slot] - 1;
      else                seq = $urandom;
      roll = $urandom_range(0, 99);
      if (pkt_count[slot] == 0) begin
        if (roll < 85) rem = $urandom_range(1, 12);
        else           rem = $urandom;
      end else begin
        if (roll < 85)      rem = run_total[slot] - pkt_count[slot];
        else if (roll < 92) rem = 1;
        else                rem = $urandom;
      end
      send_hdr(slot, seq, rem, 1'b0, '0);
    end
  endtask

  // Drive the receiver; hold it off while a backlog is being built
  always @(posedge clk) begin
    m_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Check results and watch for a stuck pipeline
  always @(negedge clk) begin
    outcome_t got;
    outcome_t want;
    if (m_tvalid && m_tready) begin
      got.res     = m_tdata[psc_pkg::RES_W-1:0];
      got.run_end = m_tlast;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with none pending");
      end else begin
        want = pending_outcomes.pop_front();
        check_flag("gap_seen", got.res.gap_seen, want.res.gap_seen);
        check_field("gap_size", got.res.gap_size, want.res.gap_size);
        check_flag("progress_mark", got.res.progress_mark, want.res.progress_mark);
        check_field("received_count", got.res.received_count,
                    want.res.received_count);
        check_flag("run_end", got.run_end, want.run_end);
        check_flag("run_ok", got.res.run_ok, want.res.run_ok);
        check_field("missing_count", got.res.missing_count, want.res.missing_count);
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    hold_rx        = 1'b0;
    src_idle_pct   = 0;
    rx_stall_pct   = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    progress_on    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      next_seq[i]  = '0;
      pkt_count[i] = '0;
      run_total[i] = '0;
    end

    // Directed table: after-reset runs, extremes, wrap, reuse, interleave
    add_typed(8'd0,   32'd0,        32'd5,        1'b0, 32'd0,        32'd1, 1'b0, 1'b0, 32'd0);
    add_typed(8'd0,   32'd1,        32'd4,        1'b0, 32'd0,        32'd2, 1'b0, 1'b0, 32'd0);
    add_typed(8'd0,   32'd5,        32'd3,        1'b1, 32'd3,        32'd3, 1'b0, 1'b0, 32'd0);
    add_typed(8'd0,   32'd6,        32'd1,        1'b0, 32'd0,        32'd4, 1'b1, 1'b0, 32'd1);
    add_typed(8'd255, 32'hffffffff, 32'hffffffff, 1'b0, 32'hffffffff, 32'd1, 1'b0, 1'b0, 32'd0);
    add_typed(8'd255, 32'd0,        32'd1,        1'b0, 32'd0,        32'd2, 1'b1, 1'b0,
              32'hfffffffd);
    add_typed(8'd7,   32'd100,      32'd1,        1'b0, 32'd100,      32'd1, 1'b1, 1'b1, 32'd0);
    add_typed(8'd7,   32'd0,        32'd0,        1'b0, 32'd0,        32'd1, 1'b0, 1'b0, 32'd0);
    add_typed(8'd7,   32'd0,        32'd1,        1'b1, 32'hffffffff, 32'd2, 1'b1, 1'b0,
              32'hfffffffe);
    add_typed(8'd8,   32'd10,       32'd3,        1'b0, 32'd10,       32'd1, 1'b0, 1'b0, 32'd0);
    add_typed(8'd9,   32'd20,       32'd2,        1'b0, 32'd20,       32'd1, 1'b0, 1'b0, 32'd0);
    add_typed(8'd8,   32'd11,       32'd2,        1'b0, 32'd0,        32'd2, 1'b0, 1'b0, 32'd0);
    add_typed(8'd9,   32'd21,       32'd1,        1'b0, 32'd0,        32'd2, 1'b1, 1'b1, 32'd0);
    add_typed(8'd8,   32'd12,       32'd1,        1'b0, 32'd0,        32'd3, 1'b1, 1'b1, 32'd0);
    add_typed(8'd8,   32'd12,       32'd1,        1'b0, 32'd12,       32'd1, 1'b1, 1'b1, 32'd0);
    add_row(8'd170, 32'haaaaaaaa, 32'h55555555);
    add_row(8'd85,  32'h55555555, 32'haaaaaaaa);
    add_row(8'd170, 32'haaaaaaab, 32'd2);
    add_row(8'd170, 32'haaaaaaac, 32'd1);
    add_row(8'd9,   32'd5,        32'd3);
    add_row(8'd9,   32'd5,        32'd2);
    add_row(8'd9,   32'd7,        32'd1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table back to back
    foreach (directed_rows[i])
      send_hdr(directed_rows[i].slot, directed_rows[i].seq, directed_rows[i].rem,
               directed_rows[i].typed, directed_rows[i].want);
    drain();

    // Random phases with different register settings and idling mixes
    set_progress(1'b1);
    send_random(80);
    drain();

    set_progress(1'b0);
    src_idle_pct = 51;
    send_random(80);
    drain();

    set_progress(1'b1);
    src_idle_pct = 0;
    rx_stall_pct = 51;
    send_random(80);
    drain();

    src_idle_pct = 21;
    rx_stall_pct = 21;
    send_random(80);
    drain();

    // Hold off the receiver long enough to back up the input
    src_idle_pct = 0;
    rx_stall_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx <= 1'b0;
      end
      begin
        send_random(30);
      end
    join
    drain();

    set_progress(1'b0);
    send_random(20);
    drain();

    repeat (8) @(posedge clk);
    if (pending_outcomes.size() != 0) report_mismatch("results still pending at end");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
src/psc_pkg.sv
src/psc_queue.sv
src/psc_front.sv
src/psc_back.sv
src/per_sender_sequence_checker_top.sv
tb/sv/testbench.sv
